FILE: hdl/fspc_pkg.sv
// Package for the five-stage pipeline machine: constants, pipeline latch types,
// opcode codes and field helpers. No dependencies.
package fspc_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 8;
  localparam int RW        = $clog2(REG_COUNT);

  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NAND = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_CMOV = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [31:0]   instr;
    logic [AW-1:0] pc1;
  } ifid_t;

  typedef struct packed {
    logic [31:0]   instr;
    logic [AW-1:0] pc1;
    logic [31:0]   ra;
    logic [31:0]   rb;
    logic [31:0]   off;
  } idex_t;

  typedef struct packed {
    logic [31:0]   instr;
    logic [AW-1:0] target;
    logic [31:0]   alu;
    logic [31:0]   rb;
  } exmem_t;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] data;
  } wbl_t;

  typedef struct packed {
    logic          ok;
    logic [RW-1:0] r;
  } dest_t;

  typedef struct packed {
    logic [AW-1:0] pc;
    logic [AW-1:0] daddr;
    logic [RW-1:0] ra;
    logic [RW-1:0] rb;
  } rd_t;

  typedef struct packed {
    logic          imem_we;
    logic          dmem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_data;
    logic          rf_we;
    logic [RW-1:0] rf_addr;
    logic [31:0]   rf_data;
  } wr_t;

  typedef struct packed {
    logic [15:0] pc_now;
    logic        wb_valid;
    logic [2:0]  wb_reg;
    logic [31:0] wb_data;
    logic        store_valid;
    logic [15:0] store_addr;
    logic [31:0] store_data;
    logic        stalled;
    logic        squashed;
    logic        halted;
    logic        fault;
    logic [31:0] cycle_count;
  } res_t;

  function automatic logic is_op(logic [31:0] w, opcode_t o);
    return w[31:22] == {7'd0, o};
  endfunction

  function automatic logic [RW-1:0] fa(logic [31:0] w);
    return w[19+:RW];
  endfunction

  function automatic logic [RW-1:0] fb(logic [31:0] w);
    return w[16+:RW];
  endfunction

  function automatic dest_t dest_of(logic [31:0] w, logic allow_lw);
    dest_t d;
    d.ok = 1'b0;
    d.r  = w[RW-1:0];
    if (is_op(w, OP_ADD) || is_op(w, OP_NAND) || is_op(w, OP_CMOV)) begin
      d.ok = 1'b1;
    end else if (is_op(w, OP_LW) && allow_lw) begin
      d.ok = 1'b1;
      d.r  = fb(w);
    end
    return d;
  endfunction

endpackage

FILE: hdl/fspc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module fspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fspc_core.sv
// Pipeline latches, hazard logic, forwarding and execute for one clock step.
// Depends on fspc_pkg; memory read data arrives from fspc_ram instances.
module fspc_core import fspc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        act,
  input  logic [15:0] laddr,
  input  logic [31:0] ldata,
  input  logic [31:0] imem_q,
  input  logic [31:0] dmem_q,
  input  logic [31:0] rfa_q,
  input  logic [31:0] rfb_q,
  output rd_t         rd,
  output wr_t         wr,
  output res_t        res
);

  logic [AW-1:0] pc, pc_next;
  ifid_t         ifid, ifid_next;
  idex_t         idex, idex_next;
  exmem_t        exmem, exmem_next;
  wbl_t          memwb, memwb_next;
  wbl_t          wbend;
  logic [31:0]   cycles, cycles_next;
  logic          stop_halt, stop_fault;

  logic          run, halt_now, fault_now, exec;
  logic          stall, squash;
  logic [31:0]   a, b;
  dest_t         d_wbe, d_mwb, d_exm, d_wb;

  assign rd.pc    = pc;
  assign rd.daddr = exmem.alu[AW-1:0];
  assign rd.ra    = fa(ifid.instr);
  assign rd.rb    = fb(ifid.instr);

  assign run       = step && act && !stop_halt && !stop_fault;
  assign halt_now  = is_op(memwb.instr, OP_HALT);
  assign fault_now = idex.instr[31:25] != 7'd0;
  assign exec      = run && !halt_now && !fault_now;

  always_comb begin
    ifid_next.instr = imem_q;
    ifid_next.pc1   = pc + 1'b1;
    pc_next         = ifid_next.pc1;

    idex_next.instr = ifid.instr;
    idex_next.pc1   = ifid.pc1;
    idex_next.ra    = rfa_q;
    idex_next.rb    = rfb_q;
    idex_next.off   = {{16{ifid.instr[15]}}, ifid.instr[15:0]};

    stall = is_op(idex.instr, OP_LW) &&
            (fa(ifid.instr) == fb(idex.instr) || fb(ifid.instr) == fb(idex.instr));
    if (stall) begin
      pc_next         = pc;
      ifid_next       = ifid;
      idex_next.instr = NOOP_WORD;
    end

    a     = idex.ra;
    b     = idex.rb;
    d_wbe = dest_of(wbend.instr, 1'b1);
    d_mwb = dest_of(memwb.instr, 1'b1);
    d_exm = dest_of(exmem.instr, 1'b0);
    if (d_wbe.ok && fa(idex.instr) == d_wbe.r) a = wbend.data;
    if (d_wbe.ok && fb(idex.instr) == d_wbe.r) b = wbend.data;
    if (d_mwb.ok && fa(idex.instr) == d_mwb.r) a = memwb.data;
    if (d_mwb.ok && fb(idex.instr) == d_mwb.r) b = memwb.data;
    if (d_exm.ok && fa(idex.instr) == d_exm.r) a = exmem.alu;
    if (d_exm.ok && fb(idex.instr) == d_exm.r) b = exmem.alu;

    exmem_next.instr  = idex.instr;
    exmem_next.target = '0;
    exmem_next.alu    = '0;
    exmem_next.rb     = b;
    unique case (opcode_t'(idex.instr[24:22]))
      OP_ADD:  exmem_next.alu = a + b;
      OP_NAND: exmem_next.alu = ~(a & b);
      OP_CMOV: begin
        if (b != 32'd0) exmem_next.alu = a;
        else            exmem_next.instr = NOOP_WORD;
      end
      OP_LW, OP_SW: exmem_next.alu = a + idex.off;
      OP_BEQ: begin
        exmem_next.alu    = {31'd0, a == b};
        exmem_next.target = idex.pc1 + idex.off[AW-1:0];
      end
      OP_HALT, OP_NOOP: ;
    endcase

    memwb_next.instr = exmem.instr;
    memwb_next.data  = '0;
    squash           = 1'b0;
    unique case (opcode_t'(exmem.instr[24:22]))
      OP_ADD, OP_NAND, OP_CMOV: memwb_next.data = exmem.alu;
      OP_LW: memwb_next.data = dmem_q;
      OP_BEQ: begin
        if (exmem.alu == 32'd1) begin
          squash           = 1'b1;
          ifid_next.instr  = NOOP_WORD;
          idex_next.instr  = NOOP_WORD;
          exmem_next.instr = NOOP_WORD;
          pc_next          = exmem.target;
        end
      end
      OP_SW, OP_HALT, OP_NOOP: ;
    endcase

    d_wb        = dest_of(memwb.instr, 1'b1);
    cycles_next = (cycles == 32'hFFFF_FFFF) ? cycles : cycles + 32'd1;
  end

  always_comb begin
    wr.imem_we  = step && !act;
    wr.dmem_we  = (step && !act) || (exec && is_op(exmem.instr, OP_SW));
    wr.mem_addr = act ? exmem.alu[AW-1:0] : laddr[AW-1:0];
    wr.mem_data = act ? exmem.rb : ldata;
    wr.rf_we    = exec && d_wb.ok;
    wr.rf_addr  = d_wb.r;
    wr.rf_data  = memwb.data;

    res             = '0;
    res.pc_now      = 16'(exec ? pc_next : pc);
    res.halted      = stop_halt || (run && halt_now);
    res.fault       = stop_fault || (run && !halt_now && fault_now);
    res.cycle_count = exec ? cycles_next : cycles;
    if (exec) begin
      res.wb_valid    = d_wb.ok;
      res.wb_reg      = d_wb.ok ? 3'(d_wb.r) : 3'd0;
      res.wb_data     = d_wb.ok ? memwb.data : 32'd0;
      res.store_valid = is_op(exmem.instr, OP_SW);
      res.store_addr  = res.store_valid ? 16'(exmem.alu[AW-1:0]) : 16'd0;
      res.store_data  = res.store_valid ? exmem.rb : 32'd0;
      res.stalled     = stall;
      res.squashed    = squash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      ifid       <= '{instr: NOOP_WORD, default: '0};
      idex       <= '{instr: NOOP_WORD, default: '0};
      exmem      <= '{instr: NOOP_WORD, default: '0};
      memwb      <= '{instr: NOOP_WORD, default: '0};
      wbend      <= '{instr: NOOP_WORD, default: '0};
      cycles     <= '0;
      stop_halt  <= 1'b0;
      stop_fault <= 1'b0;
    end else if (exec) begin
      pc     <= pc_next;
      ifid   <= ifid_next;
      idex   <= idex_next;
      exmem  <= exmem_next;
      memwb  <= memwb_next;
      wbend  <= memwb;
      cycles <= cycles_next;
    end else if (run) begin
      if (halt_now) stop_halt  <= 1'b1;
      else          stop_fault <= 1'b1;
    end
  end

endmodule

FILE: hdl/five_stage_pipeline_cpu.sv
// Five-stage pipeline machine top level: handshake, memories and result register.
// An accepted word is registered and sets busy; the core steps while busy and its
// result is registered. No new word is accepted while busy or an output stalls.
// Reset clears the pc, pipeline latches (to noop), register file valid bits,
// cycle count and stop flags; the instruction and data RAMs are not cleared.
// Depends on fspc_pkg, fspc_ram and fspc_core.
module five_stage_pipeline_cpu import fspc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] load_addr,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pc_now,
  output logic        wb_valid,
  output logic [2:0]  wb_reg,
  output logic [31:0] wb_data,
  output logic        store_valid,
  output logic [15:0] store_addr,
  output logic [31:0] store_data,
  output logic        stalled,
  output logic        squashed,
  output logic        halted,
  output logic        fault,
  output logic [31:0] cycle_count
);

  logic          busy, accept;
  logic          act;
  logic [15:0]   laddr;
  logic [31:0]   ldata;
  logic [31:0]   imem_q, dmem_q, rfa_raw, rfb_raw;
  logic [REG_COUNT-1:0] rf_ok;
  logic          ok_a, ok_b;
  rd_t           rd;
  wr_t           wr;
  res_t          res, res_reg;

  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      rf_ok     <= '0;
    end else begin
      busy <= accept;
      if (busy) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (wr.rf_we) rf_ok[wr.rf_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action;
      laddr <= load_addr;
      ldata <= load_data;
    end
    if (busy) res_reg <= res;
    ok_a <= rf_ok[rd.ra];
    ok_b <= rf_ok[rd.rb];
  end

  fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_imem (
    .clk(clk), .we(wr.imem_we), .waddr(wr.mem_addr), .wdata(wr.mem_data),
    .raddr(rd.pc), .rdata(imem_q)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(wr.dmem_we), .waddr(wr.mem_addr), .wdata(wr.mem_data),
    .raddr(rd.daddr), .rdata(dmem_q)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rfa (
    .clk(clk), .we(wr.rf_we), .waddr(wr.rf_addr), .wdata(wr.rf_data),
    .raddr(rd.ra), .rdata(rfa_raw)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rfb (
    .clk(clk), .we(wr.rf_we), .waddr(wr.rf_addr), .wdata(wr.rf_data),
    .raddr(rd.rb), .rdata(rfb_raw)
  );

  fspc_core u_core (
    .clk(clk), .rst(rst), .step(busy), .act(act), .laddr(laddr), .ldata(ldata),
    .imem_q(imem_q), .dmem_q(dmem_q),
    .rfa_q(ok_a ? rfa_raw : 32'd0), .rfb_q(ok_b ? rfb_raw : 32'd0),
    .rd(rd), .wr(wr), .res(res)
  );

  assign pc_now      = res_reg.pc_now;
  assign wb_valid    = res_reg.wb_valid;
  assign wb_reg      = res_reg.wb_reg;
  assign wb_data     = res_reg.wb_data;
  assign store_valid = res_reg.store_valid;
  assign store_addr  = res_reg.store_addr;
  assign store_data  = res_reg.store_data;
  assign stalled     = res_reg.stalled;
  assign squashed    = res_reg.squashed;
  assign halted      = res_reg.halted;
  assign fault       = res_reg.fault;
  assign cycle_count = res_reg.cycle_count;

`ifndef SYNTHESIS
  a_one_step: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("compute step lasted more than one cycle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("word accepted during compute step");
  a_result_out: assert property (@(posedge clk) disable iff (rst) busy |=> out_valid)
    else $error("compute step produced no result");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    wr.imem_we |-> !wr.rf_we)
    else $error("load and register writeback in the same step");
`endif

endmodule
